FILE: sv/nfb_pkg.sv
// Shared types and constants for the nibble framebuffer draw engine.
package nfb_pkg;

   localparam int OP_W    = 3;
   localparam int COORD_W = 10;
   localparam int COLOR_W = 4;
   localparam int THICK_W = 8;
   localparam int BAND_W  = 2;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 3'd0,
      OP_WRITE = 3'd1,
      OP_READ  = 3'd2,
      OP_HBAND = 3'd3,
      OP_VBAND = 3'd4,
      OP_BOX   = 3'd5
   } op_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CLEAR = 7'b0000010,
      ST_SETUP = 7'b0000100,
      ST_BASE  = 7'b0001000,
      ST_READ  = 7'b0010000,
      ST_WRITE = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   // box bands, in drawing order
   localparam logic [BAND_W-1:0] BAND_TOP    = 2'd0;
   localparam logic [BAND_W-1:0] BAND_BOTTOM = 2'd1;
   localparam logic [BAND_W-1:0] BAND_LEFT   = 2'd2;
   localparam logic [BAND_W-1:0] BAND_RIGHT  = 2'd3;

endpackage

FILE: sv/nfb_req_if.sv
// Request channel of the draw engine: one drawing command per request.
interface nfb_req_if
   import nfb_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [COORD_W-1:0] x_start;
   logic [COORD_W-1:0] y_start;
   logic [COORD_W-1:0] x_end;
   logic [COORD_W-1:0] y_end;
   logic [COLOR_W-1:0] color;
   logic [THICK_W-1:0] thickness;

   modport source (output valid, operation, x_start, y_start, x_end, y_end, color,
                   thickness, input ready);
   modport sink   (input valid, operation, x_start, y_start, x_end, y_end, color,
                   thickness, output ready);
endinterface

FILE: sv/nfb_rsp_if.sv
// Response channel of the draw engine: one response per request.
interface nfb_rsp_if
   import nfb_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] pixel_value;
   logic               was_read;

   modport source (output valid, pixel_value, was_read, input ready);
   modport sink   (input valid, pixel_value, was_read, output ready);
endinterface

FILE: sv/nibble_framebuffer_draw_engine_unit.sv
// Top level: 4bpp framebuffer with clear, pixel read/write, band and box fill sequencer.
//
//   channel   dir   handshake          payload
//   req_chan  in    valid/ready        operation, x/y start/end, color, thickness
//   rsp_chan  out   valid/ready        pixel_value, was_read
//
// Each pixel is a byte read-modify-write on the frame memory: READ state, then WRITE state.
// A band: SETUP, then BASE and a READ/WRITE per on-screen pixel; a box is four bands.
// Clear sweeps all ROW_BYTES*SCREEN_HEIGHT bytes of the memory one byte a cycle.
// After reset the same sweep runs before the first request is taken.
// The response sits in an output register; a new request is taken while it waits.
module nibble_framebuffer_draw_engine_unit
   import nfb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic       clock,
   input  logic       reset,
   nfb_req_if.sink    req_chan,
   nfb_rsp_if.source  rsp_chan
);

   localparam int ROW_BYTES   = (SCREEN_WIDTH + 1) / 2;
   localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
   localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int PROD_W      = 2 * COORD_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(ROW_BYTES);
   localparam logic signed [11:0] XMAX = 12'(SCREEN_WIDTH - 1);
   localparam logic signed [11:0] YMAX = 12'(SCREEN_HEIGHT - 1);

   logic [7:0] mem [STORE_BYTES];

   state_type state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic               clr_cmd_ff, clr_cmd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_pix_ff, rsp_pix_in;
   logic               rsp_rd_ff, rsp_rd_in;

   logic [OP_W-1:0]    op_ff;
   logic [COORD_W-1:0] xs_ff, ys_ff, xe_ff, ye_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [THICK_W-1:0] t_ff;
   logic [BAND_W-1:0]  band_ff, band_in;
   logic [COLOR_W-1:0] pix_ff, pix_in;

   logic [COORD_W-1:0] x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [ADDR_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0]  addr_ff;
   logic [7:0]         rd_ff;

   logic signed [11:0] xs_s, ys_s, xe_s, ye_s, t_s, bstart;
   logic signed [11:0] bx0, bx1, by0, by1, cx0, cx1, cy0, cy1;
   logic               is_h, is_v, band_empty, last_band, is_read;
   logic [PROD_W-1:0]  row_prod;
   logic [PROD_W-1:0]  addr_sum;
   logic [ADDR_W-1:0]  pix_addr;
   logic [7:0]         merged;
   logic [COLOR_W-1:0] nibble;
   logic               accept, rsp_free;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [7:0]         mem_wdata;

   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign is_read  = (op_ff == OP_READ);

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_value = rsp_pix_ff;
   assign rsp_chan.was_read    = rsp_rd_ff;

   // band bounds for the current band, as signed values, then clipped to the screen
   always_comb begin
      xs_s   = 12'(xs_ff);
      ys_s   = 12'(ys_ff);
      xe_s   = 12'(xe_ff);
      ye_s   = 12'(ye_ff);
      t_s    = 12'(t_ff);
      is_h   = 1'b0;
      is_v   = 1'b0;
      bstart = ys_s;
      case (op_ff)
         OP_HBAND: begin
            is_h   = 1'b1;
            bstart = ys_s;
         end
         OP_VBAND: begin
            is_v   = 1'b1;
            bstart = xs_s;
         end
         OP_BOX: begin
            case (band_ff)
               BAND_TOP: begin
                  is_h   = 1'b1;
                  bstart = ys_s;
               end
               BAND_BOTTOM: begin
                  is_h   = 1'b1;
                  bstart = ye_s - t_s;
               end
               BAND_LEFT: begin
                  is_v   = 1'b1;
                  bstart = xs_s;
               end
               default: begin
                  is_v   = 1'b1;
                  bstart = xe_s - t_s;
               end
            endcase
         end
         default: begin
            bstart = ys_s;
         end
      endcase

      if (is_h) begin
         bx0 = xs_s;
         bx1 = xe_s;
         by0 = bstart;
         by1 = bstart + t_s;
      end else if (is_v) begin
         bx0 = bstart;
         bx1 = bstart + t_s;
         by0 = ys_s;
         by1 = ye_s;
      end else begin
         bx0 = xs_s;
         bx1 = xs_s;
         by0 = ys_s;
         by1 = ys_s;
      end

      cx0 = (bx0 < 0) ? 12'sd0 : bx0;
      cy0 = (by0 < 0) ? 12'sd0 : by0;
      cx1 = (bx1 > XMAX) ? XMAX : bx1;
      cy1 = (by1 > YMAX) ? YMAX : by1;
      band_empty = (cx0 > cx1) || (cy0 > cy1);
      last_band  = (op_ff == OP_BOX) ? (band_ff == BAND_RIGHT) : 1'b1;
   end

   assign row_prod = y0_ff * COORD_W'(ROW_BYTES);
   assign addr_sum = PROD_W'(row_ff) + PROD_W'(x_ff[COORD_W-1:1]);
   assign pix_addr = addr_sum[ADDR_W-1:0];

   // even x sits in the high nibble
   assign merged = x_ff[0] ? {rd_ff[7:4], color_ff} : {color_ff, rd_ff[3:0]};
   assign nibble = x_ff[0] ? rd_ff[3:0] : rd_ff[7:4];

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      clr_cmd_in   = clr_cmd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pix_in   = rsp_pix_ff;
      rsp_rd_in    = rsp_rd_ff;
      band_in      = band_ff;
      pix_in       = pix_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      row_in       = row_ff;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = merged;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               band_in = '0;
               pix_in  = '0;
               case (op_type'(req_chan.operation))
                  OP_CLEAR: begin
                     clr_in     = '0;
                     clr_cmd_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  OP_WRITE, OP_READ, OP_HBAND, OP_VBAND, OP_BOX: begin
                     state_in = ST_SETUP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               clr_in   = '0;
               state_in = clr_cmd_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_SETUP: begin
            x0_in = cx0[COORD_W-1:0];
            x1_in = cx1[COORD_W-1:0];
            y0_in = cy0[COORD_W-1:0];
            y1_in = cy1[COORD_W-1:0];
            if (!band_empty) begin
               state_in = ST_BASE;
            end else if (last_band) begin
               state_in = ST_RESP;
            end else begin
               band_in = band_ff + 1'b1;
            end
         end
         ST_BASE: begin
            row_in   = row_prod[ADDR_W-1:0];
            x_in     = x0_ff;
            y_in     = y0_ff;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (is_read) begin
               pix_in   = nibble;
               state_in = ST_RESP;
            end else begin
               mem_we = 1'b1;
               if (x_ff != x1_ff) begin
                  x_in     = x_ff + 1'b1;
                  state_in = ST_READ;
               end else if (y_ff != y1_ff) begin
                  x_in     = x0_ff;
                  y_in     = y_ff + 1'b1;
                  row_in   = row_ff + ROW_STEP;
                  state_in = ST_READ;
               end else if (last_band) begin
                  state_in = ST_RESP;
               end else begin
                  band_in  = band_ff + 1'b1;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = pix_ff;
               rsp_rd_in    = is_read;
               clr_cmd_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         clr_cmd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_cmd_ff   <= clr_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_chan.operation;
         xs_ff    <= req_chan.x_start;
         ys_ff    <= req_chan.y_start;
         xe_ff    <= req_chan.x_end;
         ye_ff    <= req_chan.y_end;
         color_ff <= req_chan.color;
         t_ff     <= req_chan.thickness;
      end
      rsp_pix_ff <= rsp_pix_in;
      rsp_rd_ff  <= rsp_rd_in;
      band_ff    <= band_in;
      pix_ff     <= pix_in;
      x0_ff      <= x0_in;
      x1_ff      <= x1_in;
      y0_ff      <= y0_in;
      y1_ff      <= y1_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      row_ff     <= row_in;
   end

   // frame memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_READ) begin
         addr_ff <= pix_addr;
         rd_ff   <= mem[pix_addr];
      end
   end

endmodule

FILE: tb/tb_nibble_framebuffer_draw_engine_unit.sv
// Self-checking testbench for the 4bpp framebuffer draw engine: directed table, then random phases.
`timescale 1ns / 100ps

module tb_nibble_framebuffer_draw_engine_unit
   import nfb_pkg::*;
   ;

   localparam int FB_WIDTH  = 320;
   localparam int FB_HEIGHT = 240;
   localparam int N_DIRECTED = 25;

   // operation codes the engine ignores
   localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [COORD_W-1:0] xs;
      logic [COORD_W-1:0] ys;
      logic [COORD_W-1:0] xe;
      logic [COORD_W-1:0] ye;
      logic [COLOR_W-1:0] color;
      logic [THICK_W-1:0] thick;
   } draw_cmd_type;

   typedef struct packed {
      logic [COLOR_W-1:0] pixel_value;
      logic               was_read;
   } pix_rsp_type;

   // fixed = 1: the typed response is used instead of the predicted one
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [COORD_W-1:0] xs;
      logic [COORD_W-1:0] ys;
      logic [COORD_W-1:0] xe;
      logic [COORD_W-1:0] ye;
      logic [COLOR_W-1:0] color;
      logic [THICK_W-1:0] thick;
      logic               fixed;
      logic [COLOR_W-1:0] pixel_value;
      logic               was_read;
   } dir_row_type;

   logic clock;
   logic reset;

   nfb_req_if req_bus ();
   nfb_rsp_if rsp_bus ();

   nibble_framebuffer_draw_engine_unit #(
      .SCREEN_WIDTH  (FB_WIDTH),
      .SCREEN_HEIGHT (FB_HEIGHT)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // shadow framebuffer, one nibble per pixel
   logic [COLOR_W-1:0] frame_px [0:FB_HEIGHT-1][0:FB_WIDTH-1];

   pix_rsp_type pending_pixel_rsp [$];
   pix_rsp_type rsp_head;
   dir_row_type directed_rows [0:N_DIRECTED-1];

   int mismatch_count = 0;
   int cmd_count      = 0;
   int rsp_count      = 0;
   int read_count     = 0;
   int clear_count    = 0;
   int fill_count     = 0;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   bit quiet          = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(50_000_000);
      $display("nibble_framebuffer_draw_engine_unit: mismatch");
      $finish;
   end

   function automatic void fill_clipped(int x0, int x1, int y0, int y1,
                                        logic [COLOR_W-1:0] color);
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > FB_WIDTH - 1) x1 = FB_WIDTH - 1;
      if (y1 > FB_HEIGHT - 1) y1 = FB_HEIGHT - 1;
      for (int y = y0; y <= y1; y++)
         for (int x = x0; x <= x1; x++)
            frame_px[y][x] = color;
   endfunction

   function automatic pix_rsp_type predict_draw(draw_cmd_type c);
      int xs, ys, xe, ye, t;
      pix_rsp_type r;
      xs = int'(c.xs);
      ys = int'(c.ys);
      xe = int'(c.xe);
      ye = int'(c.ye);
      t  = int'(c.thick);
      r  = '0;
      case (c.op)
         OP_CLEAR: fill_clipped(0, FB_WIDTH - 1, 0, FB_HEIGHT - 1, '0);
         OP_WRITE: begin
            if (xs < FB_WIDTH && ys < FB_HEIGHT) frame_px[ys][xs] = c.color;
         end
         OP_READ: begin
            r.was_read = 1'b1;
            if (xs < FB_WIDTH && ys < FB_HEIGHT) r.pixel_value = frame_px[ys][xs];
         end
         OP_HBAND: fill_clipped(xs, xe, ys, ys + t, c.color);
         OP_VBAND: fill_clipped(xs, xs + t, ys, ye, c.color);
         OP_BOX: begin
            // bottom and right bands may start above or left of zero
            fill_clipped(xs, xe, ys, ys + t, c.color);
            fill_clipped(xs, xe, ye - t, ye, c.color);
            fill_clipped(xs, xs + t, ys, ye, c.color);
            fill_clipped(xe - t, xe, ys, ye, c.color);
         end
         default: ;
      endcase
      return r;
   endfunction

   // mostly a small hot window so reads land on drawn pixels; some near the far edge
   function automatic int pick_coord(int hot, int span);
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel < 6) return $urandom_range(hot - 1);
      if (sel < 9) return $urandom_range(span - 1);
      return $urandom_range(span + 10, span - 10);
   endfunction

   function automatic draw_cmd_type random_cmd();
      draw_cmd_type c;
      int unsigned sel;
      int x, y;
      sel     = $urandom_range(999);
      c.op    = OP_WRITE;
      c.xs    = COORD_W'($urandom);
      c.ys    = COORD_W'($urandom);
      c.xe    = COORD_W'($urandom);
      c.ye    = COORD_W'($urandom);
      c.color = COLOR_W'($urandom);
      c.thick = THICK_W'($urandom);
      x = pick_coord(64, FB_WIDTH);
      y = pick_coord(48, FB_HEIGHT);
      if (sel < 3) begin
         c.op = OP_CLEAR;
      end else if (sel < 600) begin
         c.op = (sel < 300) ? OP_WRITE : OP_READ;
         if ($urandom_range(9) != 0) begin
            c.xs = COORD_W'(x);
            c.ys = COORD_W'(y);
         end
      end else if (sel < 960) begin
         c.op = (sel < 720) ? OP_HBAND : (sel < 840) ? OP_VBAND : OP_BOX;
         c.xs = COORD_W'(x);
         c.ys = COORD_W'(y);
         // ends may fall short of the start, which gives an empty band
         c.xe = COORD_W'(x + $urandom_range(24) - $urandom_range(3));
         c.ye = COORD_W'(y + $urandom_range(24) - $urandom_range(3));
         if ($urandom_range(9) != 0)
            c.thick = THICK_W'($urandom_range(3));
         else if (c.op == OP_BOX)
            c.thick = THICK_W'($urandom_range(40));
         else
            c.thick = THICK_W'($urandom_range(255));
      end else if (sel < 980) begin
         c.op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
      end else begin
         // full-range corners and thickness, narrow extent keeps the cost bounded
         sel  = $urandom_range(2);
         c.op = (sel == 0) ? OP_HBAND : (sel == 1) ? OP_VBAND : OP_BOX;
         c.xe = COORD_W'(c.xs + $urandom_range(12));
         c.ye = COORD_W'(c.ys + $urandom_range(12));
      end
      return c;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_cmd(draw_cmd_type c, bit fixed, pix_rsp_type typed);
      pix_rsp_type predicted;
      while (!quiet && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.operation <= c.op;
      req_bus.x_start   <= c.xs;
      req_bus.y_start   <= c.ys;
      req_bus.x_end     <= c.xe;
      req_bus.y_end     <= c.ye;
      req_bus.color     <= c.color;
      req_bus.thickness <= c.thick;
      req_bus.valid     <= 1'b1;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      predicted = predict_draw(c);
      pending_pixel_rsp.push_back(fixed ? typed : predicted);
      cmd_count++;
      if (c.op == OP_CLEAR) clear_count++;
      if (c.op == OP_HBAND || c.op == OP_VBAND || c.op == OP_BOX) fill_count++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_pixel_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(int n_cmds, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < n_cmds; i++) begin
         quiet = (i % 50) < 8;
         send_cmd(random_cmd(), 1'b0, '0);
      end
      quiet = 1'b0;
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= quiet || ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_count++;
         if (rsp_bus.was_read) read_count++;
         if (pending_pixel_rsp.size() == 0) begin
            $error("response with no request outstanding: pixel_value %0d was_read %0d",
                   rsp_bus.pixel_value, rsp_bus.was_read);
            mismatch_count++;
         end else begin
            rsp_head = pending_pixel_rsp.pop_front();
            if (rsp_bus.pixel_value !== rsp_head.pixel_value) begin
               $error("pixel_value: expected %0d, got %0d",
                      rsp_head.pixel_value, rsp_bus.pixel_value);
               mismatch_count++;
            end
            if (rsp_bus.was_read !== rsp_head.was_read) begin
               $error("was_read: expected %0d, got %0d", rsp_head.was_read, rsp_bus.was_read);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      draw_cmd_type c;
      pix_rsp_type  typed;

      req_bus.valid     = 1'b0;
      req_bus.operation = OP_CLEAR;
      req_bus.x_start   = '0;
      req_bus.y_start   = '0;
      req_bus.x_end     = '0;
      req_bus.y_end     = '0;
      req_bus.color     = '0;
      req_bus.thickness = '0;
      reset = 1'b1;
      fill_clipped(0, FB_WIDTH - 1, 0, FB_HEIGHT - 1, '0);

      //                op         xs       ys       xe       ye      color  thick  fixed pv  rd
      directed_rows = '{
         '{OP_READ,   10'd0,   10'd0,   10'd0,    10'd0,    4'h0, 8'd0,   1'b1, 4'h0, 1'b1},
         '{OP_WRITE,  10'd0,   10'd0,   10'd0,    10'd0,    4'hF, 8'd0,   1'b1, 4'h0, 1'b0},
         '{OP_WRITE,  10'd1,   10'd0,   10'd0,    10'd0,    4'h5, 8'd0,   1'b1, 4'h0, 1'b0},
         '{OP_READ,   10'd0,   10'd0,   10'd0,    10'd0,    4'h0, 8'd0,   1'b0, 4'h0, 1'b0},
         '{OP_READ,   10'd1,   10'd0,   10'd0,    10'd0,    4'h0, 8'd0,   1'b0, 4'h0, 1'b0},
         '{OP_WRITE,  10'd319, 10'd239, 10'd0,    10'd0,    4'hA, 8'd0,   1'b1, 4'h0, 1'b0},
         '{OP_READ,   10'd319, 10'd239, 10'd0,    10'd0,    4'h0, 8'd0,   1'b0, 4'h0, 1'b0},
         '{OP_WRITE,  10'd320, 10'd0,   10'd0,    10'd0,    4'hF, 8'd0,   1'b1, 4'h0, 1'b0},
         '{OP_READ,   10'd320, 10'd0,   10'd0,    10'd0,    4'h0, 8'd0,   1'b1, 4'h0, 1'b1},
         '{OP_READ,   10'd1023, 10'd1023, 10'd0,  10'd0,    4'h0, 8'd0,   1'b1, 4'h0, 1'b1},
         '{OP_HBAND,  10'd0,   10'd10,  10'd1023, 10'd0,    4'h3, 8'd0,   1'b1, 4'h0, 1'b0},
         '{OP_HBAND,  10'd0,   10'd0,   10'd3,    10'd0,    4'h7, 8'd255, 1'b1, 4'h0, 1'b0},
         '{OP_HBAND,  10'd50,  10'd0,   10'd40,   10'd0,    4'hF, 8'd0,   1'b1, 4'h0, 1'b0},
         '{OP_VBAND,  10'd300, 10'd0,   10'd0,    10'd5,    4'h9, 8'd255, 1'b1, 4'h0, 1'b0},
         '{OP_VBAND,  10'd100, 10'd0,   10'd0,    10'd1023, 4'hC, 8'd0,   1'b1, 4'h0, 1'b0},
         '{OP_VBAND,  10'd0,   10'd20,  10'd0,    10'd10,   4'hF, 8'd3,   1'b1, 4'h0, 1'b0},
         '{OP_BOX,    10'd10,  10'd5,   10'd20,   10'd12,   4'h6, 8'd255, 1'b1, 4'h0, 1'b0},
         '{OP_BOX,    10'd30,  10'd30,  10'd60,   10'd50,   4'hE, 8'd1,   1'b1, 4'h0, 1'b0},
         '{OP_BOX,    10'd0,   10'd0,   10'd1023, 10'd1023, 4'h1, 8'd0,   1'b1, 4'h0, 1'b0},
         '{OP_READ,   10'd2,   10'd2,   10'd0,    10'd0,    4'h0, 8'd0,   1'b0, 4'h0, 1'b0},
         '{OP_SPARE6, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 4'hF, 8'd255, 1'b1, 4'h0, 1'b0},
         '{OP_SPARE7, 10'd5,   10'd5,   10'd9,    10'd9,    4'h8, 8'd2,   1'b1, 4'h0, 1'b0},
         '{OP_READ,   10'd35,  10'd30,  10'd0,    10'd0,    4'h0, 8'd0,   1'b0, 4'h0, 1'b0},
         '{OP_CLEAR,  10'd0,   10'd0,   10'd0,    10'd0,    4'h0, 8'd0,   1'b1, 4'h0, 1'b0},
         '{OP_READ,   10'd319, 10'd239, 10'd0,    10'd0,    4'h0, 8'd0,   1'b1, 4'h0, 1'b1}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         c.op              = directed_rows[i].op;
         c.xs              = directed_rows[i].xs;
         c.ys              = directed_rows[i].ys;
         c.xe              = directed_rows[i].xe;
         c.ye              = directed_rows[i].ye;
         c.color           = directed_rows[i].color;
         c.thick           = directed_rows[i].thick;
         typed.pixel_value = directed_rows[i].pixel_value;
         typed.was_read    = directed_rows[i].was_read;
         send_cmd(c, directed_rows[i].fixed, typed);
      end
      drain();

      run_phase(235, 0, 0);
      drain();
      run_phase(230, 81, 0);
      drain();
      run_phase(230, 0, 81);
      drain();
      run_phase(230, 26, 26);
      drain();
      repeat (20) @(posedge clock);

      $display("covered %0d requests (%0d from the table): %0d clears, %0d band/box fills,",
               cmd_count, N_DIRECTED, clear_count, fill_count);
      $display("  %0d responses checked, %0d of them pixel reads", rsp_count, read_count);
      if (mismatch_count == 0 && pending_pixel_rsp.size() == 0) begin
         $display("nibble_framebuffer_draw_engine_unit: match");
      end else begin
         $display("nibble_framebuffer_draw_engine_unit: mismatch");
      end
      $finish;
   end

endmodule
